>>> sv/dsac_pkg.sv
// Shared types and codes for the depth-sorted alpha compositor.
// Holds the sample kind codes and the controller/datapath command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package dsac_pkg;

  // Sample kind carried on the input tuser bit
  localparam logic CMD_BASE  = 1'b0;
  localparam logic CMD_LAYER = 1'b1;

  // Width of one 8-bit color channel
  localparam int unsigned CH_W = 8;

  // Commands from controller to datapath
  typedef struct packed {
    logic item_we;  // take the accepted beat into the pixel state
    logic mul_en;   // form the blend products for the head layer
    logic pop_en;   // round, update the running color, drop the head layer
    logic emit_en;  // load the result register and clear the pixel state
  } dsac_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic layers_empty;  // no kept layer left to blend
    logic out_free;      // result register can take a new pixel
  } dsac_status_t;

endpackage : dsac_pkg

>>> sv/depth_sorted_alpha_compositor.sv
// Each pixel is a run of input beats: an optional base sample (tuser 0) then layer
// samples (tuser 1), closed by tlast. Base and layer beats are taken back to back; the
// layer is sorted into place on arrival. After the closing beat, input stalls while the
// shared blend unit walks the sorted store one layer at a time (product, round, advance).
// The result waits in an output register while the next pixel streams in; if the
// previous result is still unread when a new one is ready, the finished pixel holds
// until the register frees and input stays stalled meanwhile.
// Layers past MAX_LAYERS are dropped and flagged in tuser.
// Top level; depends on dsac_pkg, dsac_ctrl and dsac_datapath.
`timescale 1ns / 1ps

module depth_sorted_alpha_compositor #(
  parameter int unsigned MAX_LAYERS = 8,
  parameter int unsigned DEPTH_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata from bit 0: sample_depth, sample_red, sample_green, sample_blue,
  // sample_alpha, layer_key, zero fill to whole bytes
  input  logic [((DEPTH_BITS+64+7)/8)*8-1:0] s_axis_tdata,
  input  logic                               s_axis_tuser,  // cmd
  input  logic                               s_axis_tlast,  // last_item
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: out_red, out_green, out_blue
  output logic [23:0]                        m_axis_tdata,
  output logic                               m_axis_tuser,  // layers_dropped
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);

  localparam int unsigned CH_W  = dsac_pkg::CH_W;
  localparam int unsigned R_LO  = DEPTH_BITS;
  localparam int unsigned G_LO  = R_LO + CH_W;
  localparam int unsigned B_LO  = G_LO + CH_W;
  localparam int unsigned A_LO  = B_LO + CH_W;
  localparam int unsigned K_LO  = A_LO + CH_W;

  dsac_pkg::dsac_cmd_t    cmd;
  dsac_pkg::dsac_status_t status;

  dsac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dsac_datapath #(
    .MAX_LAYERS (MAX_LAYERS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .kind_i        (s_axis_tuser),
    .depth_i       (s_axis_tdata[DEPTH_BITS-1:0]),
    .red_i         (s_axis_tdata[R_LO +: CH_W]),
    .green_i       (s_axis_tdata[G_LO +: CH_W]),
    .blue_i        (s_axis_tdata[B_LO +: CH_W]),
    .alpha_i       (s_axis_tdata[A_LO +: CH_W]),
    .key_i         (s_axis_tdata[K_LO +: 32]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_rgb_o     (m_axis_tdata),
    .out_dropped_o (m_axis_tuser)
  );

endmodule : depth_sorted_alpha_compositor

>>> sv/dsac_ctrl.sv
// Controller for the depth-sorted alpha compositor.
// Sequences item intake, the per-layer blend walk and the result hand-off.
// Depends on dsac_pkg.
`timescale 1ns / 1ps

module dsac_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  input  dsac_pkg::dsac_status_t status_i,
  output dsac_pkg::dsac_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_MUL  = 5'b00100,
    S_RND  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.item_we = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_last_i) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        state_d = status_i.layers_empty ? S_EMIT : S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_RND;
      end
      S_RND: begin
        cmd_o.pop_en = 1'b1;
        state_d      = S_WALK;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_en = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : dsac_ctrl

>>> sv/dsac_datapath.sv
// Datapath for the depth-sorted alpha compositor.
// Holds the base sample, a sorted insertion array of kept layers, the blend unit
// and the result register. Depends on dsac_pkg.
`timescale 1ns / 1ps

module dsac_datapath #(
  parameter int unsigned MAX_LAYERS = 8,
  parameter int unsigned DEPTH_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dsac_pkg::dsac_cmd_t               cmd_i,
  output dsac_pkg::dsac_status_t            status_o,
  input  logic                              kind_i,
  input  logic [DEPTH_BITS-1:0]             depth_i,
  input  logic [dsac_pkg::CH_W-1:0]         red_i,
  input  logic [dsac_pkg::CH_W-1:0]         green_i,
  input  logic [dsac_pkg::CH_W-1:0]         blue_i,
  input  logic [dsac_pkg::CH_W-1:0]         alpha_i,
  input  logic [31:0]                       key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [3*dsac_pkg::CH_W-1:0]       out_rgb_o,
  output logic                              out_dropped_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LAYERS + 1);
  localparam int unsigned CH_W  = dsac_pkg::CH_W;
  localparam int unsigned COL_W = 4 * CH_W;
  localparam int unsigned PRD_W = 2 * CH_W;
  localparam logic [DEPTH_BITS-1:0] FAR_DEPTH = '1;
  localparam logic [CH_W-1:0]       CH_MAX    = '1;

  // round(n / 255) for n up to 255*255, exact with no halfway cases
  function automatic logic [CH_W-1:0] div255_round(input logic [PRD_W-1:0] n);
    logic [PRD_W:0] t;
    logic [PRD_W:0] s;
    t = {1'b0, n} + (PRD_W+1)'(128);
    s = t + (t >> CH_W);
    return s[PRD_W-1:CH_W];
  endfunction

  // Pixel state
  logic [CH_W-1:0]       base_r_q, base_g_q, base_b_q;
  logic [DEPTH_BITS-1:0] base_depth_q;
  logic [CNT_W-1:0]      count_q;
  logic                  overflow_q;

  // Kept layers, entry 0 blends first
  logic [DEPTH_BITS-1:0] dep_q [MAX_LAYERS];
  logic [DEPTH_BITS-1:0] dep_d [MAX_LAYERS];
  logic [31:0]           key_q [MAX_LAYERS];
  logic [31:0]           key_d [MAX_LAYERS];
  logic [COL_W-1:0]      col_q [MAX_LAYERS];
  logic [COL_W-1:0]      col_d [MAX_LAYERS];

  logic [MAX_LAYERS-1:0] stay;
  logic                  qualifies;
  logic                  store_full;
  logic                  do_insert;
  logic                  do_drop;
  logic                  take_base;

  // Blend products
  logic [PRD_W-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [CH_W-1:0]  head_a, head_ia;

  // Result register
  logic                 out_valid_q;
  logic [3*CH_W-1:0]    out_rgb_q;
  logic                 out_drop_q;

  assign qualifies  = (depth_i < base_depth_q) && (depth_i < FAR_DEPTH);
  assign store_full = (count_q == CNT_W'(MAX_LAYERS));
  assign take_base  = cmd_i.item_we && (kind_i == dsac_pkg::CMD_BASE);
  assign do_insert  = cmd_i.item_we && (kind_i == dsac_pkg::CMD_LAYER) && qualifies &&
                      !store_full;
  assign do_drop    = cmd_i.item_we && (kind_i == dsac_pkg::CMD_LAYER) && qualifies &&
                      store_full;

  // Mark entries that stay ahead of the new layer
  always_comb begin
    for (int i = 0; i < MAX_LAYERS; i++) begin
      stay[i] = (CNT_W'(i) < count_q) &&
                !((depth_i > dep_q[i]) || ((depth_i == dep_q[i]) && (key_i < key_q[i])));
    end
  end

  // Next array contents: insert, pop or hold
  always_comb begin
    for (int i = 0; i < MAX_LAYERS; i++) begin
      dep_d[i] = dep_q[i];
      key_d[i] = key_q[i];
      col_d[i] = col_q[i];
    end
    if (do_insert) begin
      if (!stay[0]) begin
        dep_d[0] = depth_i;
        key_d[0] = key_i;
        col_d[0] = {red_i, green_i, blue_i, alpha_i};
      end
      for (int i = 1; i < MAX_LAYERS; i++) begin
        if (!stay[i]) begin
          if (stay[i-1]) begin
            dep_d[i] = depth_i;
            key_d[i] = key_i;
            col_d[i] = {red_i, green_i, blue_i, alpha_i};
          end else begin
            dep_d[i] = dep_q[i-1];
            key_d[i] = key_q[i-1];
            col_d[i] = col_q[i-1];
          end
        end
      end
    end else if (cmd_i.pop_en) begin
      for (int i = 0; i + 1 < MAX_LAYERS; i++) begin
        dep_d[i] = dep_q[i+1];
        key_d[i] = key_q[i+1];
        col_d[i] = col_q[i+1];
      end
    end
  end

  // Hold the layer array
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_LAYERS; i++) begin
      dep_q[i] <= dep_d[i];
      key_q[i] <= key_d[i];
      col_q[i] <= col_d[i];
    end
  end

  // Form c*a + o*(255-a) for the head layer
  assign head_a  = col_q[0][CH_W-1:0];
  assign head_ia = CH_MAX - head_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_r_q <= col_q[0][4*CH_W-1:3*CH_W] * head_a + base_r_q * head_ia;
      prod_g_q <= col_q[0][3*CH_W-1:2*CH_W] * head_a + base_g_q * head_ia;
      prod_b_q <= col_q[0][2*CH_W-1:CH_W]   * head_a + base_b_q * head_ia;
    end
  end

  // Pixel state: base load, blend update, layer count, clear after emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_r_q     <= '0;
      base_g_q     <= '0;
      base_b_q     <= '0;
      base_depth_q <= FAR_DEPTH;
      count_q      <= '0;
      overflow_q   <= 1'b0;
    end else if (cmd_i.emit_en) begin
      base_r_q     <= '0;
      base_g_q     <= '0;
      base_b_q     <= '0;
      base_depth_q <= FAR_DEPTH;
      count_q      <= '0;
      overflow_q   <= 1'b0;
    end else if (take_base) begin
      base_r_q     <= red_i;
      base_g_q     <= green_i;
      base_b_q     <= blue_i;
      base_depth_q <= depth_i;
      count_q      <= '0;
      overflow_q   <= 1'b0;
    end else if (do_insert) begin
      count_q <= count_q + CNT_W'(1);
    end else if (do_drop) begin
      overflow_q <= 1'b1;
    end else if (cmd_i.pop_en) begin
      base_r_q <= div255_round(prod_r_q);
      base_g_q <= div255_round(prod_g_q);
      base_b_q <= div255_round(prod_b_q);
      count_q  <= count_q - CNT_W'(1);
    end
  end

  // Result register, freed when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      out_rgb_q  <= {base_b_q, base_g_q, base_r_q};
      out_drop_q <= overflow_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_rgb_o             = out_rgb_q;
  assign out_dropped_o         = out_drop_q;
  assign status_o.layers_empty = (count_q == '0);
  assign status_o.out_free     = !out_valid_q || out_ready_i;

endmodule : dsac_datapath
